// File: design/sstq_pkg.sv
// ----------------------------------------------------------------------------
// sstq_pkg: shared types and codes of the sorted sleep timer queue
// Field widths, command and status codes, queue entry layout and the
// sequencer state type.
// ----------------------------------------------------------------------------
package sstq_pkg;

    // field widths
    localparam int ID_W    = 8;
    localparam int MS_W    = 32;
    localparam int ALARM_W = 64;
    localparam int STAT_W  = 3;

    // at most this many wake-ups are reported per tick
    localparam int RES_LIMIT = 16;
    localparam int WAKE_W    = 5;

    // command codes carried in s_tuser
    localparam logic CMD_SLEEP = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // result status codes carried in m_tuser
    localparam logic [STAT_W-1:0] STAT_QUEUED    = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] STAT_CANCELLED = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] STAT_WOKEN     = 3'd4;

    // one queue entry as held in the entry memory
    typedef struct packed {
        logic [ALARM_W-1:0] alarm;
        logic [ID_W-1:0]    id;
    } entry_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_MUL,
        ST_DIV_EST,
        ST_DIV_FIX,
        ST_INS_WALK,
        ST_INS_PUT,
        ST_CAN_SRCH,
        ST_CAN_SHIFT,
        ST_CAN_REM,
        ST_REPLY,
        ST_WAKE_RD,
        ST_WAKE_CHK,
        ST_WAKE_LAST
    } state_t;

endpackage

// File: design/sstq_ram.sv
// ----------------------------------------------------------------------------
// sstq_ram: generic single-clock RAM
// One write port and one read port, read data registered and held while
// no read is requested.
// ----------------------------------------------------------------------------
module sstq_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/sorted_sleep_timer_queue.sv
// ----------------------------------------------------------------------------
// sorted_sleep_timer_queue: tick counter and wake-up ordered sleep queue
// Entries live in a ring held in one RAM; a sequencer inserts, cancels and
// wakes them with read-modify-write walks.
// ----------------------------------------------------------------------------
// Input beats (s_*): s_tuser selects a sleep/cancel request or a timer tick.
// A sleep with non-zero ms queues the pid behind every entry with an alarm
// earlier or equal; zero ms cancels the first entry of that pid.
// Result beats (m_*): one per request, one per woken entry on a tick, with
// m_tlast on the final result of the input beat. A tick that wakes nothing
// gives no beat.
// Sleeps and cancels walk the ring one entry at a time through the single
// read port of the entry memory; a tick wakes at most 16 entries.
// One beat is handled at a time; s_tready is high while the sequencer is idle.
// A finished result sits in an output register, so the next beat is taken
// while it waits; a stalled receiver holds the sequencer only when a further
// result is ready to go. Reset empties the queue and clears the tick count.
// ----------------------------------------------------------------------------
module sorted_sleep_timer_queue
    import sstq_pkg::*;
#(
    parameter int MAX_SLEEPERS = 16,
    parameter int TICK_MS      = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // proc_id[7:0], sleep_ms[39:8]
    input  logic        s_tuser,    // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // out_id[7:0], remaining_ms[39:8]
    output logic [2:0]  m_tuser,    // status
    output logic        m_tlast
);

    // ring addressing and counts
    localparam int AW    = $clog2(MAX_SLEEPERS);
    localparam int CW    = $clog2(MAX_SLEEPERS + 1);
    localparam int DEPTH = 2 ** AW;

    // ms to ticks by reciprocal multiply, exact after one correction
    localparam int          TW     = $clog2(TICK_MS + 1);
    localparam int          SH     = 31 + $clog2(TICK_MS);
    localparam logic [63:0] RECIPW = (64'd1 << SH) / TICK_MS;
    localparam logic [31:0] RECIP  = RECIPW[31:0];
    localparam logic [TW-1:0] TVAL = TICK_MS[TW-1:0];
    localparam logic [63:0] LIMIT  = 64'h0000_0000_FFFF_FFFF / TICK_MS;
    localparam logic [CW-1:0] CAP  = CW'(MAX_SLEEPERS);

    state_t               state_reg, state_next;
    logic [ALARM_W-1:0]   now_reg, now_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic [WAKE_W-1:0]    n_reg, n_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]      pend_id_reg, pend_id_next;
    logic [ID_W-1:0]      pid_reg, pid_next;
    logic [MS_W-1:0]      ms_reg, ms_next;
    logic [63:0]          prod_reg, prod_next;
    logic [31:0]          quo_reg, quo_next;
    logic [31:0]          qt_reg, qt_next;
    logic [ALARM_W-1:0]   alarm_reg, alarm_next;
    logic [ALARM_W-1:0]   diff_reg, diff_next;
    logic                 gt_reg, gt_next;
    logic [STAT_W-1:0]    reply_stat_reg, reply_stat_next;
    logic [MS_W-1:0]      reply_rem_reg, reply_rem_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]    out_stat_reg, out_stat_next;
    logic [ID_W-1:0]      out_id_reg, out_id_next;
    logic [MS_W-1:0]      out_rem_reg, out_rem_next;
    logic                 out_last_reg, out_last_next;

    // entry memory ports
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    entry_t               ram_wdata, ram_rdata;

    // datapath helpers
    logic [63:0]          shifted;
    logic [31+TW:0]       qt_full;
    logic [31:0]          div_rem;
    logic [31:0]          quo_fix;
    logic [31+TW:0]       can_prod;
    logic [CW-1:0]        idx_m1, idx_m2, idx_p1, idx_p2;
    logic [CW:0]          idx_p1_w, idx_p2_w;
    logic                 out_free;
    logic                 due;
    entry_t               new_entry;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                           input logic [CW-1:0] li);
        slot = head + li[AW-1:0];
    endfunction

    sstq_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // handshake and port packing
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_rem_reg, out_id_reg};
    assign m_tuser  = out_stat_reg;
    assign m_tlast  = out_last_reg;
    assign out_free = !out_valid_reg || m_tready;

    // divider and index arithmetic
    assign shifted   = prod_reg >> SH;
    assign qt_full   = shifted[31:0] * TVAL;
    assign div_rem   = ms_reg - qt_reg;
    assign quo_fix   = (div_rem >= 32'(TICK_MS)) ? quo_reg + 32'd1 : quo_reg;
    assign can_prod  = diff_reg[31:0] * TVAL;
    assign idx_m1    = idx_reg - CW'(1);
    assign idx_m2    = idx_reg - CW'(2);
    assign idx_p1    = idx_reg + CW'(1);
    assign idx_p2    = idx_reg + CW'(2);
    assign idx_p1_w  = {1'b0, idx_reg} + (CW+1)'(1);
    assign idx_p2_w  = {1'b0, idx_reg} + (CW+1)'(2);
    assign due       = (ram_rdata.alarm <= now_reg);
    assign new_entry = '{alarm: alarm_reg, id: pid_reg};

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pid_next        = pid_reg;
        ms_next         = ms_reg;
        prod_next       = prod_reg;
        quo_next        = quo_reg;
        qt_next         = qt_reg;
        alarm_next      = alarm_reg;
        diff_next       = diff_reg;
        gt_next         = gt_reg;
        reply_stat_next = reply_stat_reg;
        reply_rem_next  = reply_rem_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_stat_next   = out_stat_reg;
        out_id_next     = out_id_reg;
        out_rem_next    = out_rem_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = slot(head_reg, idx_reg);
        ram_wdata       = new_entry;
        ram_re          = 1'b0;
        ram_raddr       = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    pid_next = s_tdata[7:0];
                    ms_next  = s_tdata[39:8];
                    if (s_tuser == CMD_TICK)
                    begin
                        now_next        = now_reg + 64'd1;
                        n_next          = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_WAKE_RD;
                    end
                    else if (s_tdata[39:8] == '0)
                    begin
                        idx_next = '0;
                        reply_rem_next = '0;
                        if (count_reg == '0)
                        begin
                            reply_stat_next = STAT_NOT_FOUND;
                            state_next      = ST_REPLY;
                        end
                        else
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = head_reg;
                            state_next = ST_CAN_SRCH;
                        end
                    end
                    else if (count_reg >= CAP)
                    begin
                        reply_stat_next = STAT_FULL;
                        reply_rem_next  = '0;
                        state_next      = ST_REPLY;
                    end
                    else
                    begin
                        state_next = ST_DIV_MUL;
                    end
                end
            end

            // estimate of ms / TICK_MS
            ST_DIV_MUL:
            begin
                prod_next  = {32'd0, ms_reg} * {32'd0, RECIP};
                state_next = ST_DIV_EST;
            end

            ST_DIV_EST:
            begin
                quo_next   = shifted[31:0];
                qt_next    = qt_full[31:0];
                state_next = ST_DIV_FIX;
            end

            // correct quotient, form alarm, start walking from the tail
            ST_DIV_FIX:
            begin
                alarm_next = now_reg + {32'd0, quo_fix};
                idx_next   = count_reg;
                if (count_reg == '0)
                begin
                    state_next = ST_INS_PUT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = slot(head_reg, count_reg - CW'(1));
                    state_next = ST_INS_WALK;
                end
            end

            // move later alarms up by one until the slot is found
            ST_INS_WALK:
            begin
                ram_we    = 1'b1;
                ram_waddr = slot(head_reg, idx_reg);
                if (ram_rdata.alarm > alarm_reg)
                begin
                    ram_wdata = ram_rdata;
                    idx_next  = idx_m1;
                    if (idx_m1 == '0)
                    begin
                        state_next = ST_INS_PUT;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = slot(head_reg, idx_m2);
                    end
                end
                else
                begin
                    ram_wdata       = new_entry;
                    count_next      = count_reg + CW'(1);
                    reply_stat_next = STAT_QUEUED;
                    reply_rem_next  = '0;
                    state_next      = ST_REPLY;
                end
            end

            ST_INS_PUT:
            begin
                ram_we          = 1'b1;
                ram_waddr       = slot(head_reg, idx_reg);
                ram_wdata       = new_entry;
                count_next      = count_reg + CW'(1);
                reply_stat_next = STAT_QUEUED;
                reply_rem_next  = '0;
                state_next      = ST_REPLY;
            end

            // search for the first entry of the pid
            ST_CAN_SRCH:
            begin
                if (ram_rdata.id == pid_reg)
                begin
                    gt_next   = ram_rdata.alarm > now_reg;
                    diff_next = ram_rdata.alarm - now_reg;
                    if (idx_p1_w < {1'b0, count_reg})
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = slot(head_reg, idx_p1);
                        state_next = ST_CAN_SHIFT;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = ST_CAN_REM;
                    end
                end
                else if (idx_p1_w < {1'b0, count_reg})
                begin
                    idx_next  = idx_p1;
                    ram_re    = 1'b1;
                    ram_raddr = slot(head_reg, idx_p1);
                end
                else
                begin
                    reply_stat_next = STAT_NOT_FOUND;
                    reply_rem_next  = '0;
                    state_next      = ST_REPLY;
                end
            end

            // close the gap behind the removed entry
            ST_CAN_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = slot(head_reg, idx_reg);
                ram_wdata = ram_rdata;
                idx_next  = idx_p1;
                if (idx_p2_w < {1'b0, count_reg})
                begin
                    ram_re    = 1'b1;
                    ram_raddr = slot(head_reg, idx_p2);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = ST_CAN_REM;
                end
            end

            // remaining time in ms, saturated
            ST_CAN_REM:
            begin
                reply_stat_next = STAT_CANCELLED;
                if (!gt_reg)
                begin
                    reply_rem_next = '0;
                end
                else if (diff_reg > LIMIT)
                begin
                    reply_rem_next = '1;
                end
                else
                begin
                    reply_rem_next = can_prod[31:0];
                end
                state_next = ST_REPLY;
            end

            ST_REPLY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = reply_stat_reg;
                    out_id_next    = pid_reg;
                    out_rem_next   = reply_rem_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            // fetch the head entry while more may be woken
            ST_WAKE_RD:
            begin
                if ((count_reg != '0) && (n_reg < WAKE_W'(RES_LIMIT)))
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = head_reg;
                    state_next = ST_WAKE_CHK;
                end
                else if (pend_valid_reg)
                begin
                    state_next = ST_WAKE_LAST;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            // send the held wake-up, marked last when the head is not due
            ST_WAKE_CHK:
            begin
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_stat_next  = STAT_WOKEN;
                        out_id_next    = pend_id_reg;
                        out_rem_next   = '0;
                        out_last_next  = !due;
                    end
                    if (due)
                    begin
                        pend_valid_next = 1'b1;
                        pend_id_next    = ram_rdata.id;
                        head_next       = head_reg + AW'(1);
                        count_next      = count_reg - CW'(1);
                        n_next          = n_reg + WAKE_W'(1);
                        state_next      = ST_WAKE_RD;
                    end
                    else
                    begin
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end

            ST_WAKE_LAST:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_stat_next   = STAT_WOKEN;
                    out_id_next     = pend_id_reg;
                    out_rem_next    = '0;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_id_reg    <= pend_id_next;
        pid_reg        <= pid_next;
        ms_reg         <= ms_next;
        prod_reg       <= prod_next;
        quo_reg        <= quo_next;
        qt_reg         <= qt_next;
        alarm_reg      <= alarm_next;
        diff_reg       <= diff_next;
        gt_reg         <= gt_next;
        reply_stat_reg <= reply_stat_next;
        reply_rem_reg  <= reply_rem_next;
        out_stat_reg   <= out_stat_next;
        out_id_reg     <= out_id_next;
        out_rem_reg    <= out_rem_next;
        out_last_reg   <= out_last_next;
    end

endmodule

// File: test/sstq_result_checker.sv
// ----------------------------------------------------------------------------
// sstq_result_checker: scoreboard for the sorted sleep timer queue
// Watches both stream channels, keeps its own tick count and ordered list
// of sleepers, works out the result beats of every accepted input beat and
// compares each accepted result beat field by field with the oldest one due.
// ----------------------------------------------------------------------------
module sstq_result_checker
    import sstq_pkg::*;
#(
    parameter int MAX_SLEEPERS = 16,
    parameter int TICK_MS      = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,    // proc_id[7:0], sleep_ms[39:8]
    input  logic        s_tuser,    // cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,    // out_id[7:0], remaining_ms[39:8]
    input  logic [2:0]  m_tuser,    // status
    input  logic        m_tlast,
    output int          fail_count,
    output int          waiting,
    output int          results_seen,
    output int          woken_seen,
    output int          full_seen,
    output int          cancelled_seen
);

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [ID_W-1:0]   id;
        logic [MS_W-1:0]   rem_ms;
        logic              last;
    } timer_result_t;

    typedef struct {
        logic [ALARM_W-1:0] alarm;
        logic [ID_W-1:0]    id;
    } sleeper_t;

    // predicted state of the block
    logic [ALARM_W-1:0] tick_now;
    sleeper_t           sleepers[$];
    timer_result_t      due_results[$];

    // next state and result beats for one accepted input beat
    task automatic advance_timer_queue(input logic cmd, input logic [ID_W-1:0] pid,
                                       input logic [MS_W-1:0] ms);
        logic [ALARM_W-1:0] alarm;
        logic [ALARM_W-1:0] diff;
        logic [MS_W-1:0]    rem;
        int                 pos;
        int                 n;
        if (cmd == CMD_TICK)
        begin
            // one tick: wake every due sleeper from the head, capped per tick
            tick_now = tick_now + 64'd1;
            n = 0;
            while (sleepers.size() > 0 && n < RES_LIMIT && sleepers[0].alarm <= tick_now)
            begin
                due_results.push_back('{STAT_WOKEN, sleepers[0].id, 32'd0, 1'b0});
                void'(sleepers.pop_front());
                n++;
            end
            if (n > 0)
                due_results[due_results.size()-1].last = 1'b1;
        end
        else if (ms == '0)
        begin
            // cancel the first sleeper of this pid in queue order
            pos = 0;
            while (pos < sleepers.size() && sleepers[pos].id != pid)
                pos++;
            if (pos < sleepers.size())
            begin
                rem = '0;
                if (sleepers[pos].alarm > tick_now)
                begin
                    diff = sleepers[pos].alarm - tick_now;
                    if (diff > 64'(32'hFFFF_FFFF) / 64'(TICK_MS))
                        rem = 32'hFFFF_FFFF;
                    else
                        rem = 32'(diff * 64'(TICK_MS));
                end
                sleepers.delete(pos);
                due_results.push_back('{STAT_CANCELLED, pid, rem, 1'b1});
            end
            else
            begin
                due_results.push_back('{STAT_NOT_FOUND, pid, 32'd0, 1'b1});
            end
        end
        else if (sleepers.size() >= MAX_SLEEPERS)
        begin
            due_results.push_back('{STAT_FULL, pid, 32'd0, 1'b1});
        end
        else
        begin
            // insert behind every sleeper with an earlier or equal alarm
            alarm = tick_now + 64'(ms) / 64'(TICK_MS);
            pos = 0;
            while (pos < sleepers.size() && sleepers[pos].alarm <= alarm)
                pos++;
            sleepers.insert(pos, '{alarm, pid});
            due_results.push_back('{STAT_QUEUED, pid, 32'd0, 1'b1});
        end
    endtask

    // compare one result beat with the oldest one due
    task automatic check_result_beat();
        timer_result_t exp_r;
        if (due_results.size() == 0)
        begin
            $error("unexpected result beat: status %0d id %0d remaining_ms %0d",
                   m_tuser, m_tdata[7:0], m_tdata[39:8]);
            fail_count++;
        end
        else
        begin
            exp_r = due_results.pop_front();
            if (m_tuser !== exp_r.status)
            begin
                $error("status: expected %0d, got %0d", exp_r.status, m_tuser);
                fail_count++;
            end
            if (m_tdata[7:0] !== exp_r.id)
            begin
                $error("out_id: expected %0d, got %0d", exp_r.id, m_tdata[7:0]);
                fail_count++;
            end
            if (m_tdata[39:8] !== exp_r.rem_ms)
            begin
                $error("remaining_ms: expected %0d, got %0d", exp_r.rem_ms, m_tdata[39:8]);
                fail_count++;
            end
            if (m_tlast !== exp_r.last)
            begin
                $error("last: expected %0d, got %0d", exp_r.last, m_tlast);
                fail_count++;
            end
        end
        results_seen++;
        if (m_tuser == STAT_WOKEN)
            woken_seen++;
        if (m_tuser == STAT_FULL)
            full_seen++;
        if (m_tuser == STAT_CANCELLED)
            cancelled_seen++;
    endtask

    // results are checked before the new beat is predicted, since a beat
    // taken at this edge cannot have a result out at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_now = '0;
            sleepers.delete();
            due_results.delete();
            fail_count = 0;
            results_seen = 0;
            woken_seen = 0;
            full_seen = 0;
            cancelled_seen = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result_beat();
            if (s_tvalid && s_tready)
                advance_timer_queue(s_tuser, s_tdata[7:0], s_tdata[39:8]);
        end
        waiting = due_results.size();
    end

endmodule

// File: test/tb_sorted_sleep_timer_queue.sv
// ----------------------------------------------------------------------------
// tb_sorted_sleep_timer_queue: stimulus and verdict for the sleep timer queue
// Sends directed beats (empty queue, short and longest sleeps, duplicate
// pids, cancels, a full queue and a tick waking many equal alarms), then
// random sleeps, cancels and ticks with random idling on both sides, one
// long receiver stall and one drain pause. A checker beside the block
// predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_sorted_sleep_timer_queue
    import sstq_pkg::*;
;

    localparam int MAX_SLEEPERS   = 16;
    localparam int TICK_MS        = 10;
    localparam int RANDOM_BEATS   = 134;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT     = 3000;
    localparam int DRAIN_CYCLES   = 50;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // proc_id[7:0], sleep_ms[39:8]
    logic        s_tuser;    // cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // out_id[7:0], remaining_ms[39:8]
    logic [2:0]  m_tuser;    // status
    logic        m_tlast;

    int fail_count;
    int waiting;
    int results_seen;
    int woken_seen;
    int full_seen;
    int cancelled_seen;
    int beats_sent;
    int idle_cycles;
    bit calm;
    bit rx_hold_req;
    bit rx_hold_done;

    sorted_sleep_timer_queue #(
        .MAX_SLEEPERS (MAX_SLEEPERS),
        .TICK_MS      (TICK_MS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    sstq_result_checker #(
        .MAX_SLEEPERS (MAX_SLEEPERS),
        .TICK_MS      (TICK_MS)
    ) u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .fail_count     (fail_count),
        .waiting        (waiting),
        .results_seen   (results_seen),
        .woken_seen     (woken_seen),
        .full_seen      (full_seen),
        .cancelled_seen (cancelled_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // one input beat, with an optional idle burst in front of it
    task automatic send_beat(input logic cmd, input logic [ID_W-1:0] pid,
                             input logic [MS_W-1:0] ms);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {ms, pid};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        beats_sent++;
    endtask

    // pid from a small pool most of the time, so that cancels find sleepers
    function automatic logic [ID_W-1:0] pick_pid();
        if ($urandom_range(0, 3) == 0)
            return ID_W'($urandom_range(0, 255));
        return ID_W'($urandom_range(0, 7));
    endfunction

    // one random beat: ticks, short and long sleeps, cancels hit and miss
    task automatic send_random_beat();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 30)
            send_beat(CMD_TICK, ID_W'($urandom), $urandom);
        else if (kind < 55)
            send_beat(CMD_SLEEP, pick_pid(), MS_W'($urandom_range(1, 8 * TICK_MS)));
        else if (kind < 62)
            send_beat(CMD_SLEEP, pick_pid(), MS_W'($urandom_range(1, TICK_MS - 1)));
        else if (kind < 70)
            send_beat(CMD_SLEEP, ID_W'($urandom), $urandom);
        else if (kind < 90)
            send_beat(CMD_SLEEP, pick_pid(), '0);
        else
            send_beat(CMD_SLEEP, ID_W'($urandom_range(0, 255)), '0);
    endtask

    // receiver: random stall bursts, one long hold on request
    initial
    begin
        m_tready = 1'b0;
        rx_hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req && !rx_hold_done)
            begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES - 1) @(negedge clk);
                rx_hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("sorted_sleep_timer_queue: mismatch");
                $finish;
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_SLEEP;
        calm = 1'b0;
        rx_hold_req = 1'b0;
        beats_sent = 0;
        idle_cycles = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty queue: tick wakes nothing, cancel finds nothing
        send_beat(CMD_TICK, 8'd0, 32'd0);
        send_beat(CMD_SLEEP, 8'd0, 32'd0);
        // short sleep, longest sleep, duplicate pid
        send_beat(CMD_SLEEP, 8'd0, 32'd1);
        send_beat(CMD_SLEEP, 8'd255, 32'hFFFF_FFFF);
        send_beat(CMD_SLEEP, 8'd0, 32'(2 * TICK_MS));
        // cancel with long remaining time, then the first of the duplicates
        send_beat(CMD_SLEEP, 8'd255, 32'd0);
        send_beat(CMD_SLEEP, 8'd0, 32'd0);
        // equal alarms fill the queue, the last one finds it full
        for (int k = 1; k <= MAX_SLEEPERS; k++)
            send_beat(CMD_SLEEP, ID_W'(16 + k), 32'(3 * TICK_MS));
        // ticks: nothing due, one due, then many equal alarms at once
        repeat (3) send_beat(CMD_TICK, 8'hFF, 32'hFFFF_FFFF);

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i == 40)
                rx_hold_req = 1'b1;
            if (i == 90)
            begin
                // hold the sender until every result is back
                s_tvalid <= 1'b0;
                wait (waiting == 0);
                @(negedge clk);
            end
            if (i == RANDOM_BEATS - 30)
                calm = 1'b1;
            send_random_beat();
        end
        s_tvalid <= 1'b0;

        wait (waiting == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d input beats and %0d result beats", beats_sent, results_seen);
        $display("  of which %0d woken, %0d cancelled, %0d refused with a full queue",
                 woken_seen, cancelled_seen, full_seen);
        if (fail_count == 0)
            $display("sorted_sleep_timer_queue: match");
        else
            $display("sorted_sleep_timer_queue: mismatch");
        $finish;
    end

endmodule

// File: sim.f
design/sstq_pkg.sv
design/sstq_ram.sv
design/sorted_sleep_timer_queue.sv
test/sstq_result_checker.sv
test/tb_sorted_sleep_timer_queue.sv
